@@ sv/tsi_pkg.sv @@
`default_nettype none
package tsi_pkg;
    localparam int BUFFER_DEPTH = 16;
    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int NCH = 6;
    localparam int CH_W = 3;
    localparam logic [31:0] MAX_GAP_RESET = 32'd200000;
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_SYNC = 1'b1;
    typedef logic [NCH*32-1:0] t_vel;
    typedef struct packed {
        logic start;
        logic [63:0] mag;
        logic [31:0] den;
    } t_div_req;
endpackage
`default_nettype wire

@@ sv/tsi_ram.sv @@
`default_nettype none
module tsi_ram #(
    parameter int AW = 4,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/tsi_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle, 64-bit dividend
module tsi_div
    import tsi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output logic          o_done,
    output logic [63:0]   o_quo
);
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    always_comb begin
        n_shift = {r_rem[31:0], r_q[63]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= i_req.mag;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                if (!n_trial[32]) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_q;
endmodule
`default_nettype wire

@@ sv/tsi_ctrl.sv @@
`default_nettype none
module tsi_ctrl
    import tsi_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,
    input  wire logic         i_start,
    input  wire logic         i_op,
    input  wire logic [31:0]  i_stamp,
    input  wire t_vel         i_vel,
    output logic              o_busy,
    output logic              o_res_valid,
    output logic              o_res_ok,
    output logic [31:0]       o_res_stamp,
    output t_vel              o_res_vel,
    input  wire logic         i_res_taken
);
    typedef enum logic [3:0] {
        S_IDLE, S_RDF, S_RDB, S_CHECK, S_RDV, S_RDVB, S_MUL, S_SUM, S_DIV, S_DONE
    } t_state;

    t_state            r_state;
    logic [31:0]       r_gap;
    logic [IDX_W-1:0]  r_old;
    logic [CNT_W-1:0]  r_fill;
    logic [31:0]       r_t;
    logic [31:0]       r_tf;
    logic [31:0]       r_tb;
    logic [CH_W-1:0]   r_ch;
    logic [31:0]       r_vf;
    logic signed [63:0] r_pf;
    logic signed [63:0] r_pb;
    logic              r_neg;
    t_vel              r_out;
    logic              r_ok;
    logic              r_valid;
    logic              r_res_ok;
    logic [31:0]       r_res_stamp;
    t_vel              r_res_vel;

    logic              n_twe;
    logic [IDX_W-1:0]  n_taddr;
    logic [IDX_W-1:0]  n_traddr;
    logic [31:0]       t_rd;
    logic              n_vwe;
    logic [IDX_W+CH_W-1:0] n_vwaddr;
    logic [IDX_W+CH_W-1:0] n_vraddr;
    logic [31:0]       v_rd;
    logic [CH_W-1:0]   r_wch;
    logic              r_wact;
    t_vel              r_wvel;
    logic [IDX_W-1:0]  r_wslot;
    logic [IDX_W-1:0]  n_slot_new;
    logic [IDX_W-1:0]  n_sb;
    t_div_req          n_div;
    logic              div_done;
    logic [63:0]       div_q;
    logic signed [64:0] n_sum;
    logic [63:0]       n_mag;
    logic [31:0]       n_d;
    logic [31:0]       n_res;

    tsi_ram #(.AW(IDX_W), .DW(32)) u_tram (
        .i_clk(i_clk), .i_we(n_twe), .i_waddr(n_taddr), .i_wdata(i_stamp),
        .i_raddr(n_traddr), .o_rdata(t_rd));
    tsi_ram #(.AW(IDX_W+CH_W), .DW(32)) u_vram (
        .i_clk(i_clk), .i_we(n_vwe), .i_waddr(n_vwaddr),
        .i_wdata(r_wvel[r_wch*32 +: 32]), .i_raddr(n_vraddr), .o_rdata(v_rd));
    tsi_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_div),
        .o_done(div_done), .o_quo(div_q));

    always_comb begin
        // full ring: the new sample overwrites the oldest slot
        n_slot_new = (r_fill == CNT_W'(BUFFER_DEPTH)) ? r_old
                                                       : r_old + r_fill[IDX_W-1:0];
        n_sb     = r_old + IDX_W'(1);
        n_twe    = i_start && i_op == OP_PUSH;
        n_taddr  = n_slot_new;
        n_traddr = (r_state == S_RDF) ? r_old : n_sb;
        n_vwe    = r_wact;
        n_vwaddr = {r_wslot, r_wch};
        n_vraddr = (r_state == S_RDV) ? {r_old, r_ch} : {n_sb, r_ch};
        n_d      = r_tb - r_tf;
        n_sum    = 65'(r_pf) + 65'(r_pb);
        n_mag    = n_sum[64] ? 64'(-n_sum) : n_sum[63:0];
        n_div.start = r_state == S_SUM && n_d != 32'd0;
        n_div.mag   = n_mag + 64'(n_d >> 1);
        n_div.den   = n_d;
        if (r_neg) n_res = (div_q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_q);
        else       n_res = (div_q > 64'h7fff_ffff) ? 32'h7fff_ffff : div_q[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gap   <= MAX_GAP_RESET;
            r_old   <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
            r_wact  <= 1'b0;
        end else begin
            if (i_cfg_we) r_gap <= i_cfg_wdata;
            if (r_state == S_DONE && (!r_valid || i_res_taken)) r_valid <= 1'b1;
            else if (i_res_taken) r_valid <= 1'b0;
            if (r_wact) begin
                r_wch <= r_wch + CH_W'(1);
                if (r_wch == CH_W'(NCH-1)) r_wact <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_t <= i_stamp;
                        if (i_op == OP_PUSH) begin
                            r_wact  <= 1'b1;
                            r_wch   <= '0;
                            r_wvel  <= i_vel;
                            r_wslot <= n_slot_new;
                            if (r_fill == CNT_W'(BUFFER_DEPTH)) r_old <= r_old + IDX_W'(1);
                            else r_fill <= r_fill + CNT_W'(1);
                        end else begin
                            r_out   <= '0;
                            r_ok    <= 1'b0;
                            r_state <= S_RDF;
                        end
                    end
                end
                S_RDF: r_state <= (r_fill < CNT_W'(2)) ? S_DONE : S_RDB;
                S_RDB: begin
                    r_tf    <= t_rd;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_tf > r_t) r_state <= S_DONE;
                    else if (t_rd < r_t) begin
                        r_old   <= r_old + IDX_W'(1);
                        r_fill  <= r_fill - CNT_W'(1);
                        r_state <= S_RDF;
                    end else if (r_t - r_tf > r_gap || t_rd - r_t > r_gap) begin
                        r_old   <= r_old + IDX_W'(1);
                        r_fill  <= r_fill - CNT_W'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_tb    <= t_rd;
                        r_ok    <= 1'b1;
                        r_ch    <= '0;
                        r_state <= S_RDV;
                    end
                end
                S_RDV: r_state <= S_RDVB;
                S_RDVB: begin
                    r_vf    <= v_rd;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pf    <= $signed(r_vf) * $signed({1'b0, r_tb - r_t});
                    r_pb    <= $signed(v_rd) * $signed({1'b0, r_t - r_tf});
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_neg <= n_sum[64];
                    if (n_d == 32'd0) begin
                        r_out[r_ch*32 +: 32] <= r_vf;
                        r_state <= (r_ch == CH_W'(NCH-1)) ? S_DONE : S_RDV;
                        r_ch    <= r_ch + CH_W'(1);
                    end else r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out[r_ch*32 +: 32] <= n_res;
                        r_state <= (r_ch == CH_W'(NCH-1)) ? S_DONE : S_RDV;
                        r_ch    <= r_ch + CH_W'(1);
                    end
                end
                S_DONE: begin
                    // hand over to the output register once it is free
                    if (!r_valid || i_res_taken) begin
                        r_res_ok    <= r_ok;
                        r_res_vel   <= r_out;
                        r_res_stamp <= r_t;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = r_state != S_IDLE || r_wact;
    assign o_res_valid = r_valid;
    assign o_res_ok    = r_res_ok;
    assign o_res_stamp = r_res_stamp;
    assign o_res_vel   = r_res_vel;
endmodule
`default_nettype wire

@@ sv/timestamp_sync_interpolator_top.sv @@
`default_nettype none
// Timestamp sync interpolator.
// Slave stream: one beat is a push (tuser = 0) storing a stamped six-axis velocity
// sample in a 16-entry ring, or a sync request (tuser = 1) asking for velocity at
// tdata stamp. A sync returns one master beat: tuser = ok, tdata = stamp then the
// six interpolated channels (zero on failure). Pushes return nothing.
// A push writes the six channels into the velocity RAM one after another; the
// slave is not ready until they are written. A sync walks the ring through the
// time RAM, dropping old samples until the stamp lies between two, then for
// each channel reads the velocity RAM, multiplies and runs the serial divider.
// The 64-bit divide, one quotient bit a cycle, is the longest step; equal
// neighbour stamps skip it. The result beat sits in an output register apart
// from the working registers; the next beat is taken while it waits, and a
// further sync runs but holds in S_DONE until the receiver takes the pending beat.
// Reset: ring empty, max gap 200000 us. No clearing pass; RAMs hold stale data
// that is never read. i_cfg_we writes max_gap_us; use only while idle.
module timestamp_sync_interpolator_top
    import tsi_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [223:0] s_axis_tdata,  // stamp_us, lin_x..z, ang_x..z
    input  wire logic         s_axis_tuser,  // op
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [223:0]      m_axis_tdata,  // out_stamp_us, out_lin_x..z, out_ang_x..z
    output logic              m_axis_tuser,  // ok
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata
);
    logic busy, res_valid, res_ok, start;
    t_vel res_vel;
    logic [31:0] res_stamp;

    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && s_axis_tready;

    tsi_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_start(start), .i_op(s_axis_tuser), .i_stamp(s_axis_tdata[31:0]),
        .i_vel(s_axis_tdata[223:32]), .o_busy(busy), .o_res_valid(res_valid),
        .o_res_ok(res_ok), .o_res_stamp(res_stamp), .o_res_vel(res_vel),
        .i_res_taken(m_axis_tready));

    assign m_axis_tvalid = res_valid;
    assign m_axis_tuser  = res_ok;
    assign m_axis_tdata  = {res_vel, res_stamp};
endmodule
`default_nettype wire

@@ sv/tsi_check.sv @@
`default_nettype none
module tsi_check (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic         m_axis_tuser,
    input wire logic [223:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[223:32] == '0)
        else $error("failed sync carries data");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("beat taken while busy");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid out of reset");
endmodule
bind timestamp_sync_interpolator_top tsi_check u_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
    .m_axis_tdata(m_axis_tdata));
`default_nettype wire
